### rtl/jpt_pkg.sv
`timescale 1ns / 1ps
// jpt_pkg: shared types, codes and helper functions of the jsonc pair tokenizer
// used by jpt_front, jpt_fifo, jpt_back and jsonc_pair_tokenizer; no dependencies

package jpt_pkg;

  localparam int unsigned MaxResults   = 4;
  localparam int unsigned FifoDepthDef = 4;

  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_VAL  = 2'd1;
  localparam logic [1:0] KIND_PAIR = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [1:0] REASON_BRACE = 2'd0;
  localparam logic [1:0] REASON_RUNOUT = 2'd1;
  localparam logic [1:0] REASON_SYNTAX = 2'd2;

  localparam logic [1:0] CTX_OPEN  = 2'd0;
  localparam logic [1:0] CTX_KEY   = 2'd1;
  localparam logic [1:0] CTX_COLON = 2'd2;
  localparam logic [1:0] CTX_VALUE = 2'd3;

  typedef enum logic [11:0] {
    PH_START = 12'b0000_0000_0001,
    PH_BOM1  = 12'b0000_0000_0010,
    PH_BOM2  = 12'b0000_0000_0100,
    PH_SKIP  = 12'b0000_0000_1000,
    PH_SLASH = 12'b0000_0001_0000,
    PH_LINE  = 12'b0000_0010_0000,
    PH_BLOCK = 12'b0000_0100_0000,
    PH_BSTAR = 12'b0000_1000_0000,
    PH_STR   = 12'b0001_0000_0000,
    PH_ESC   = 12'b0010_0000_0000,
    PH_HEX   = 12'b0100_0000_0000,
    PH_DONE  = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text;
    logic       kept;
    logic       any;
    logic [1:0] reason;
  } res_t;

  // cnt is 0..MaxResults; only bundles with cnt 1..MaxResults are queued
  typedef struct packed {
    logic [2:0]            cnt;
    res_t [MaxResults-1:0] res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    unique case (b)
      8'h62: c = 8'h08;
      8'h66: c = 8'h0C;
      8'h6E: c = 8'h0A;
      8'h72: c = 8'h0D;
      8'h74: c = 8'h09;
      default: c = b;
    endcase
    return c;
  endfunction

endpackage

### rtl/jsonc_pair_tokenizer.sv
`timescale 1ns / 1ps
// jsonc_pair_tokenizer: top level, streaming tokenizer for flat jsonc string pairs
// depends on jpt_pkg, jpt_front, jpt_fifo and jpt_back
//
// usage:
//   input channel s_*: one document byte per item, s_tlast marks the last byte.
//   output channel m_*: one token item per transfer; m_tuser is the kind
//   (key byte, value byte, pair end, stream end), m_tlast marks the last item
//   caused by one input byte.
//   each input byte is parsed in the cycle it is accepted and its results
//   (zero to four) go into a bundle queue of FifoDepth entries.
//   the first result of a byte is written into the queue and then loaded into
//   the output register.
//   throughput: one input byte per cycle while the queue has room; the output
//   side moves one item per cycle while m_tready is high, so bytes that expand
//   into several items (utf-8 escapes, final byte) are absorbed by the queue.
//   reset clears the parser state, queue and output register; the next byte
//   starts a new document. a stall on m_tready fills the queue and then
//   drops s_tready; nothing is lost. after the final byte a stream end item
//   is sent and the parser returns to its reset state.

module jsonc_pair_tokenizer #(
  parameter int unsigned FifoDepth = jpt_pkg::FifoDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // text_byte[7:0], pair_kept, any_pair, end_reason[1:0], zeros
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last_of_run
);

  logic                accept;
  logic                push;
  logic                pop;
  jpt_pkg::bundle_t    wr_bundle;
  jpt_pkg::bundle_t    head;
  jpt_pkg::fifo_stat_t stat;
  jpt_pkg::res_t       m_res;

  assign s_tready = !stat.full;
  assign accept   = s_tvalid && s_tready;

  jpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .push       (push),
    .bundle     (wr_bundle)
  );

  jpt_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_bundle),
    .pop     (pop),
    .rd_data (head),
    .stat    (stat)
  );

  jpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!stat.empty),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_res      (m_res),
    .m_last     (m_tlast)
  );

  assign m_tuser = m_res.kind;
  assign m_tdata = {4'd0, m_res.reason, m_res.any, m_res.kept, m_res.text};

  a_push_room : assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("bundle written into a full queue");

  a_pop_data : assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("bundle taken from an empty queue");

  a_end_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == jpt_pkg::KIND_END) |-> m_tlast)
    else $error("stream end item not marked last of its run");

  a_bundle_cnt : assert property (@(posedge clk) disable iff (rst)
    (!stat.empty) |-> (head.cnt != 3'd0 && head.cnt <= 3'(jpt_pkg::MaxResults)))
    else $error("queued bundle holds no results or too many");

endmodule

### rtl/jpt_front.sv
`timescale 1ns / 1ps
// jpt_front: byte classifier and parser state, one byte per cycle while accept is high
// packs all results of a byte into one bundle; uses jpt_pkg

module jpt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  output logic              push,
  output jpt_pkg::bundle_t  bundle
);

  jpt_pkg::phase_t phase, phase_next;
  logic [1:0]  skip_ctx, skip_ctx_next;
  logic        in_value, in_value_next;
  logic [15:0] hex_acc, hex_acc_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic        key_ne, key_ne_next;
  logic        val_ne, val_ne_next;
  logic        pair_seen, pair_seen_next;
  logic [1:0]  stop_reason, stop_reason_next;

  always_comb begin
    logic        tok;
    logic        pe;
    logic        kept;
    logic [1:0]  ntext;
    logic [7:0]  t0, t1, t2;
    logic [4:0]  hd;
    logic [15:0] cp;
    logic [2:0]  n;
    logic [1:0]  reason;
    jpt_pkg::res_t txt;

    phase_next       = phase;
    skip_ctx_next    = skip_ctx;
    in_value_next    = in_value;
    hex_acc_next     = hex_acc;
    hex_cnt_next     = hex_cnt;
    key_ne_next      = key_ne;
    val_ne_next      = val_ne;
    pair_seen_next   = pair_seen;
    stop_reason_next = stop_reason;
    tok    = 1'b0;
    pe     = 1'b0;
    kept   = key_ne & val_ne;
    ntext  = 2'd0;
    t0     = data_byte;
    t1     = 8'd0;
    t2     = 8'd0;
    hd     = jpt_pkg::hex_digit(data_byte);
    cp     = {hex_acc[11:0], hd[3:0]};
    n      = 3'd0;
    reason = jpt_pkg::REASON_RUNOUT;
    txt    = '0;
    bundle = '0;

    unique case (phase)
      jpt_pkg::PH_START: begin
        if (data_byte == 8'hEF) begin
          phase_next = jpt_pkg::PH_BOM1;
        end else begin
          phase_next = jpt_pkg::PH_SKIP;
          tok = 1'b1;
        end
      end
      jpt_pkg::PH_BOM1: begin
        if (data_byte == 8'hBB) begin
          phase_next = jpt_pkg::PH_BOM2;
        end else begin
          phase_next = jpt_pkg::PH_DONE;
          stop_reason_next = jpt_pkg::REASON_SYNTAX;
        end
      end
      jpt_pkg::PH_BOM2: begin
        if (data_byte == 8'hBF) begin
          phase_next = jpt_pkg::PH_SKIP;
        end else begin
          phase_next = jpt_pkg::PH_DONE;
          stop_reason_next = jpt_pkg::REASON_SYNTAX;
        end
      end
      jpt_pkg::PH_SKIP: tok = 1'b1;
      jpt_pkg::PH_SLASH: begin
        if (data_byte == 8'h2F) begin
          phase_next = jpt_pkg::PH_LINE;
        end else if (data_byte == 8'h2A) begin
          phase_next = jpt_pkg::PH_BLOCK;
        end else begin
          phase_next = jpt_pkg::PH_DONE;
          stop_reason_next = jpt_pkg::REASON_SYNTAX;
        end
      end
      jpt_pkg::PH_LINE: begin
        if (data_byte == 8'h0A || data_byte == 8'h0D) phase_next = jpt_pkg::PH_SKIP;
      end
      jpt_pkg::PH_BLOCK: begin
        if (data_byte == 8'h2A) phase_next = jpt_pkg::PH_BSTAR;
      end
      jpt_pkg::PH_BSTAR: begin
        if (data_byte == 8'h2F) begin
          phase_next = jpt_pkg::PH_SKIP;
        end else if (data_byte != 8'h2A) begin
          phase_next = jpt_pkg::PH_BLOCK;
        end
      end
      jpt_pkg::PH_STR: begin
        if (data_byte == 8'h22) begin
          if (in_value) begin
            pe = 1'b1;
            if (kept) pair_seen_next = 1'b1;
            skip_ctx_next = jpt_pkg::CTX_KEY;
          end else begin
            skip_ctx_next = jpt_pkg::CTX_COLON;
          end
          phase_next = jpt_pkg::PH_SKIP;
        end else if (data_byte == 8'h5C) begin
          phase_next = jpt_pkg::PH_ESC;
        end else begin
          ntext = 2'd1;
        end
      end
      jpt_pkg::PH_ESC: begin
        if (data_byte == 8'h75) begin
          phase_next   = jpt_pkg::PH_HEX;
          hex_acc_next = 16'd0;
          hex_cnt_next = 2'd0;
        end else begin
          ntext = 2'd1;
          t0 = jpt_pkg::esc_map(data_byte);
          phase_next = jpt_pkg::PH_STR;
        end
      end
      jpt_pkg::PH_HEX: begin
        if (!hd[4]) begin
          phase_next = jpt_pkg::PH_DONE;
          stop_reason_next = jpt_pkg::REASON_SYNTAX;
        end else begin
          hex_acc_next = cp;
          if (hex_cnt == 2'd3) begin
            // utf-8 encoding of the code point
            if (cp <= 16'h007F) begin
              ntext = 2'd1;
              t0 = cp[7:0];
            end else if (cp <= 16'h07FF) begin
              ntext = 2'd2;
              t0 = 8'hC0 | {3'd0, cp[10:6]};
              t1 = 8'h80 | {2'd0, cp[5:0]};
            end else begin
              ntext = 2'd3;
              t0 = 8'hE0 | {4'd0, cp[15:12]};
              t1 = 8'h80 | {2'd0, cp[11:6]};
              t2 = 8'h80 | {2'd0, cp[5:0]};
            end
            hex_cnt_next = 2'd0;
            phase_next = jpt_pkg::PH_STR;
          end else begin
            hex_cnt_next = hex_cnt + 2'd1;
          end
        end
      end
      jpt_pkg::PH_DONE: ;
      default: ;
    endcase

    if (tok) begin
      priority if (data_byte == 8'h20 || data_byte == 8'h09 || data_byte == 8'h0D ||
                   data_byte == 8'h0A || data_byte == 8'h2C) begin
        phase_next = jpt_pkg::PH_SKIP;
      end else if (data_byte == 8'h2F) begin
        phase_next = jpt_pkg::PH_SLASH;
      end else begin
        phase_next = jpt_pkg::PH_DONE;
        stop_reason_next = jpt_pkg::REASON_SYNTAX;
        unique case (skip_ctx)
          jpt_pkg::CTX_OPEN: begin
            if (data_byte == 8'h7B) begin
              phase_next = jpt_pkg::PH_SKIP;
              stop_reason_next = stop_reason;
              skip_ctx_next = jpt_pkg::CTX_KEY;
            end
          end
          jpt_pkg::CTX_KEY: begin
            if (data_byte == 8'h7D) begin
              stop_reason_next = jpt_pkg::REASON_BRACE;
            end else if (data_byte == 8'h22) begin
              phase_next = jpt_pkg::PH_STR;
              stop_reason_next = stop_reason;
              in_value_next = 1'b0;
              key_ne_next = 1'b0;
            end
          end
          jpt_pkg::CTX_COLON: begin
            if (data_byte == 8'h3A) begin
              phase_next = jpt_pkg::PH_SKIP;
              stop_reason_next = stop_reason;
              skip_ctx_next = jpt_pkg::CTX_VALUE;
            end
          end
          jpt_pkg::CTX_VALUE: begin
            if (data_byte == 8'h22) begin
              phase_next = jpt_pkg::PH_STR;
              stop_reason_next = stop_reason;
              in_value_next = 1'b1;
              val_ne_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end

    if (ntext != 2'd0) begin
      if (in_value) val_ne_next = 1'b1;
      else key_ne_next = 1'b1;
    end

    txt.kind = in_value ? jpt_pkg::KIND_VAL : jpt_pkg::KIND_KEY;
    if (pe) begin
      bundle.res[0]      = '0;
      bundle.res[0].kind = jpt_pkg::KIND_PAIR;
      bundle.res[0].kept = kept;
      n = 3'd1;
    end
    if (ntext >= 2'd1) begin
      bundle.res[0] = txt;
      bundle.res[0].text = t0;
    end
    if (ntext >= 2'd2) begin
      bundle.res[1] = txt;
      bundle.res[1].text = t1;
    end
    if (ntext == 2'd3) begin
      bundle.res[2] = txt;
      bundle.res[2].text = t2;
    end
    if (ntext != 2'd0) n = {1'b0, ntext};

    if (final_byte) begin
      priority if (phase_next == jpt_pkg::PH_DONE) begin
        reason = stop_reason_next;
      end else if (phase_next == jpt_pkg::PH_SLASH || phase_next == jpt_pkg::PH_BOM1 ||
                   phase_next == jpt_pkg::PH_BOM2 || phase_next == jpt_pkg::PH_START) begin
        reason = jpt_pkg::REASON_SYNTAX;
      end else begin
        reason = jpt_pkg::REASON_RUNOUT;
      end
      bundle.res[n[1:0]]        = '0;
      bundle.res[n[1:0]].kind   = jpt_pkg::KIND_END;
      bundle.res[n[1:0]].any    = pair_seen_next;
      bundle.res[n[1:0]].reason = reason;
      n = n + 3'd1;
      // next byte starts a new document
      phase_next       = jpt_pkg::PH_START;
      skip_ctx_next    = jpt_pkg::CTX_OPEN;
      in_value_next    = 1'b0;
      hex_acc_next     = 16'd0;
      hex_cnt_next     = 2'd0;
      key_ne_next      = 1'b0;
      val_ne_next      = 1'b0;
      pair_seen_next   = 1'b0;
      stop_reason_next = jpt_pkg::REASON_BRACE;
    end
    bundle.cnt = n;
  end

  assign push = accept && (bundle.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= jpt_pkg::PH_START;
      skip_ctx    <= jpt_pkg::CTX_OPEN;
      in_value    <= 1'b0;
      hex_acc     <= 16'd0;
      hex_cnt     <= 2'd0;
      key_ne      <= 1'b0;
      val_ne      <= 1'b0;
      pair_seen   <= 1'b0;
      stop_reason <= jpt_pkg::REASON_BRACE;
    end else if (accept) begin
      phase       <= phase_next;
      skip_ctx    <= skip_ctx_next;
      in_value    <= in_value_next;
      hex_acc     <= hex_acc_next;
      hex_cnt     <= hex_cnt_next;
      key_ne      <= key_ne_next;
      val_ne      <= val_ne_next;
      pair_seen   <= pair_seen_next;
      stop_reason <= stop_reason_next;
    end
  end

endmodule

### rtl/jpt_fifo.sv
`timescale 1ns / 1ps
// jpt_fifo: short queue of result bundles between front and back
// uses jpt_pkg for the bundle and status types

module jpt_fifo #(
  parameter int unsigned Depth = jpt_pkg::FifoDepthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jpt_pkg::bundle_t    wr_data,
  input  logic                pop,
  output jpt_pkg::bundle_t    rd_data,
  output jpt_pkg::fifo_stat_t stat
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  jpt_pkg::bundle_t mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CW'(Depth));
  assign stat.empty = (count == '0);
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

### rtl/jpt_back.sv
`timescale 1ns / 1ps
// jpt_back: unpacks queued bundles into single result items in an output register
// uses jpt_pkg for the bundle and result types

module jpt_back (
  input  logic             clk,
  input  logic             rst,
  input  jpt_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output jpt_pkg::res_t    m_res,
  output logic             m_last
);

  logic [1:0] idx;
  logic       load;
  logic       last;

  assign load = head_valid && (!m_tvalid || m_tready);
  assign last = ({1'b0, idx} + 3'd1) == head.cnt;
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= last ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res  <= head.res[idx];
      m_last <= last;
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for jsonc_pair_tokenizer, feeds jsonc documents byte by byte
// and checks every token item against a behavioral tokenizer kept in this file
// depends on jpt_pkg and jsonc_pair_tokenizer

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailItems  = 40;

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] TAB    = 8'h09;
  localparam logic [7:0] LF     = 8'h0A;
  localparam logic [7:0] CR     = 8'h0D;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    logic       hold;
  } doc_byte_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] text;
    logic       kept;
    logic       any_pair;
    logic [1:0] reason;
    logic       run_end;
  } token_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  doc_byte_t   doc_feed[$];
  logic [7:0]  doc_bytes[$];
  token_t      due_tokens[$];
  token_t      step_tokens[$];

  logic        nothing_due = 1'b1;
  int          mismatches = 0;
  int          total_items = 0;
  int          bytes_taken = 0;
  int          src_gap = 0;
  int          src_calm = 0;
  int          sink_gap = 0;
  int          sink_calm = 0;
  int unsigned cycle_count = 0;

  // tokenizer state
  jpt_pkg::phase_t tok_phase;
  logic [1:0]  tok_ctx;
  logic        in_val;
  logic [15:0] hex_acc;
  logic [1:0]  hex_cnt;
  logic        key_has;
  logic        val_has;
  logic        kept_any;
  logic [1:0]  halt_reason;

  jsonc_pair_tokenizer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic clear_parser;
    tok_phase   = jpt_pkg::PH_START;
    tok_ctx     = jpt_pkg::CTX_OPEN;
    in_val      = 1'b0;
    hex_acc     = 16'h0000;
    hex_cnt     = 2'd0;
    key_has     = 1'b0;
    val_has     = 1'b0;
    kept_any    = 1'b0;
    halt_reason = jpt_pkg::REASON_BRACE;
  endtask

  task automatic push_token(input logic [1:0] kind, input logic [7:0] text, input logic kept,
                            input logic any_pair, input logic [1:0] reason);
    token_t t;
    t.kind     = kind;
    t.text     = text;
    t.kept     = kept;
    t.any_pair = any_pair;
    t.reason   = reason;
    t.run_end  = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endtask

  task automatic emit_text(input logic [7:0] b);
    if (in_val) begin
      val_has = 1'b1;
      push_token(jpt_pkg::KIND_VAL, b, 1'b0, 1'b0, jpt_pkg::REASON_BRACE);
    end else begin
      key_has = 1'b1;
      push_token(jpt_pkg::KIND_KEY, b, 1'b0, 1'b0, jpt_pkg::REASON_BRACE);
    end
  endtask

  task automatic stop_parse(input logic [1:0] why);
    tok_phase   = jpt_pkg::PH_DONE;
    halt_reason = why;
  endtask

  task automatic between_tokens(input logic [7:0] b);
    if (b == " " || b == TAB || b == CR || b == LF || b == ",") begin
      return;
    end
    if (b == "/") begin
      tok_phase = jpt_pkg::PH_SLASH;
      return;
    end
    case (tok_ctx)
      jpt_pkg::CTX_OPEN: begin
        if (b == "{") tok_ctx = jpt_pkg::CTX_KEY;
        else stop_parse(jpt_pkg::REASON_SYNTAX);
      end
      jpt_pkg::CTX_KEY: begin
        if (b == "}") begin
          stop_parse(jpt_pkg::REASON_BRACE);
        end else if (b == QUOTE) begin
          tok_phase = jpt_pkg::PH_STR;
          in_val    = 1'b0;
          key_has   = 1'b0;
        end else begin
          stop_parse(jpt_pkg::REASON_SYNTAX);
        end
      end
      jpt_pkg::CTX_COLON: begin
        if (b == ":") tok_ctx = jpt_pkg::CTX_VALUE;
        else stop_parse(jpt_pkg::REASON_SYNTAX);
      end
      default: begin
        if (b == QUOTE) begin
          tok_phase = jpt_pkg::PH_STR;
          in_val    = 1'b1;
          val_has   = 1'b0;
        end else begin
          stop_parse(jpt_pkg::REASON_SYNTAX);
        end
      end
    endcase
  endtask

  // works out the token items one input byte causes and queues them
  task automatic tokenize_byte(input logic [7:0] b, input logic fin);
    int          hv;
    logic [15:0] cp;
    logic [1:0]  why;
    step_tokens.delete();
    case (tok_phase)
      jpt_pkg::PH_START: begin
        if (b == 8'hEF) begin
          tok_phase = jpt_pkg::PH_BOM1;
        end else begin
          tok_phase = jpt_pkg::PH_SKIP;
          between_tokens(b);
        end
      end
      jpt_pkg::PH_BOM1: begin
        if (b == 8'hBB) tok_phase = jpt_pkg::PH_BOM2;
        else stop_parse(jpt_pkg::REASON_SYNTAX);
      end
      jpt_pkg::PH_BOM2: begin
        if (b == 8'hBF) tok_phase = jpt_pkg::PH_SKIP;
        else stop_parse(jpt_pkg::REASON_SYNTAX);
      end
      jpt_pkg::PH_SKIP: between_tokens(b);
      jpt_pkg::PH_SLASH: begin
        if (b == "/") tok_phase = jpt_pkg::PH_LINE;
        else if (b == "*") tok_phase = jpt_pkg::PH_BLOCK;
        else stop_parse(jpt_pkg::REASON_SYNTAX);
      end
      jpt_pkg::PH_LINE: begin
        if (b == LF || b == CR) tok_phase = jpt_pkg::PH_SKIP;
      end
      jpt_pkg::PH_BLOCK: begin
        if (b == "*") tok_phase = jpt_pkg::PH_BSTAR;
      end
      jpt_pkg::PH_BSTAR: begin
        if (b == "/") tok_phase = jpt_pkg::PH_SKIP;
        else if (b != "*") tok_phase = jpt_pkg::PH_BLOCK;
      end
      jpt_pkg::PH_STR: begin
        if (b == QUOTE) begin
          if (in_val) begin
            push_token(jpt_pkg::KIND_PAIR, 8'h00, key_has && val_has, 1'b0,
                       jpt_pkg::REASON_BRACE);
            if (key_has && val_has) kept_any = 1'b1;
            tok_ctx = jpt_pkg::CTX_KEY;
          end else begin
            tok_ctx = jpt_pkg::CTX_COLON;
          end
          tok_phase = jpt_pkg::PH_SKIP;
        end else if (b == BSLASH) begin
          tok_phase = jpt_pkg::PH_ESC;
        end else begin
          emit_text(b);
        end
      end
      jpt_pkg::PH_ESC: begin
        if (b == "u") begin
          tok_phase = jpt_pkg::PH_HEX;
          hex_acc   = 16'h0000;
          hex_cnt   = 2'd0;
        end else begin
          case (b)
            "b": emit_text(8'h08);
            "f": emit_text(8'h0C);
            "n": emit_text(LF);
            "r": emit_text(CR);
            "t": emit_text(TAB);
            default: emit_text(b);
          endcase
          tok_phase = jpt_pkg::PH_STR;
        end
      end
      jpt_pkg::PH_HEX: begin
        hv = -1;
        if (b >= "0" && b <= "9") hv = b - 8'h30;
        else if (b >= "a" && b <= "f") hv = b - 8'h61 + 10;
        else if (b >= "A" && b <= "F") hv = b - 8'h41 + 10;
        if (hv < 0) begin
          stop_parse(jpt_pkg::REASON_SYNTAX);
        end else begin
          hex_acc = {hex_acc[11:0], 4'(hv)};
          if (hex_cnt == 2'd3) begin
            cp = hex_acc;
            if (cp <= 16'h007F) begin
              emit_text(cp[7:0]);
            end else if (cp <= 16'h07FF) begin
              emit_text({3'b110, cp[10:6]});
              emit_text({2'b10, cp[5:0]});
            end else begin
              emit_text({4'b1110, cp[15:12]});
              emit_text({2'b10, cp[11:6]});
              emit_text({2'b10, cp[5:0]});
            end
            hex_cnt   = 2'd0;
            tok_phase = jpt_pkg::PH_STR;
          end else begin
            hex_cnt = hex_cnt + 2'd1;
          end
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (tok_phase == jpt_pkg::PH_DONE) why = halt_reason;
      else if (tok_phase inside {jpt_pkg::PH_SLASH, jpt_pkg::PH_BOM1, jpt_pkg::PH_BOM2,
                                 jpt_pkg::PH_START}) why = jpt_pkg::REASON_SYNTAX;
      else why = jpt_pkg::REASON_RUNOUT;
      push_token(jpt_pkg::KIND_END, 8'h00, 1'b0, kept_any, why);
      clear_parser();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].run_end = 1'b1;
    foreach (step_tokens[i]) due_tokens.insert(due_tokens.size(), step_tokens[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // document generation
  task automatic add_byte(input logic [7:0] b);
    doc_bytes.insert(doc_bytes.size(), b);
  endtask

  task automatic commit_doc(input bit hold_first);
    doc_byte_t e;
    foreach (doc_bytes[i]) begin
      e.data = doc_bytes[i];
      e.fin  = (i == doc_bytes.size() - 1);
      e.hold = hold_first && (i == 0);
      doc_feed.insert(doc_feed.size(), e);
    end
    doc_bytes.delete();
  endtask

  task automatic add_hex4(input logic [15:0] cp);
    logic [3:0] nib;
    bit         upper;
    upper = $urandom_range(0, 1);
    for (int i = 3; i >= 0; i--) begin
      nib = cp[4*i +: 4];
      if (nib < 4'd10) add_byte(8'(8'h30 + nib));
      else add_byte(8'((upper ? 8'h41 : 8'h61) + nib - 4'd10));
    end
  endtask

  task automatic add_string;
    logic [7:0]  b;
    logic [15:0] cp;
    logic [15:0] cp_edges[6];
    string       simple;
    simple   = "bfnrt\"\\/";
    cp_edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4: add_byte(8'($urandom_range(8'h61, 8'h7A)));
        5: begin
          do b = 8'($urandom_range(0, 255)); while (b == QUOTE || b == BSLASH);
          add_byte(b);
        end
        6: begin
          add_byte(BSLASH);
          add_byte(simple[$urandom_range(0, 7)]);
        end
        7: begin
          do b = 8'($urandom_range(0, 255)); while (b == "u");
          add_byte(BSLASH);
          add_byte(b);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: cp = 16'($urandom_range(0, 16'h007F));
            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            default: cp = cp_edges[$urandom_range(0, 5)];
          endcase
          add_byte(BSLASH);
          add_byte("u");
          add_hex4(cp);
        end
      endcase
    end
  endtask

  task automatic add_filler;
    string body_chars;
    body_chars = "a* ";
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 6))
        0: add_byte(" ");
        1: add_byte(TAB);
        2: add_byte(CR);
        3: add_byte(LF);
        4: add_byte(",");
        5: begin
          add_byte("/");
          add_byte("/");
          repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(8'h61, 8'h7A)));
          add_byte($urandom_range(0, 1) ? LF : CR);
        end
        default: begin
          add_byte("/");
          add_byte("*");
          repeat ($urandom_range(0, 4)) add_byte(body_chars[$urandom_range(0, 2)]);
          add_byte("*");
          add_byte("/");
        end
      endcase
    end
  endtask

  task automatic build_doc;
    doc_bytes.delete();
    if ($urandom_range(0, 3) == 0) begin
      add_byte(8'hEF);
      add_byte(8'hBB);
      add_byte(8'hBF);
    end
    add_filler();
    add_byte("{");
    add_filler();
    repeat ($urandom_range(0, 3)) begin
      add_byte(QUOTE);
      add_string();
      add_byte(QUOTE);
      add_filler();
      add_byte(":");
      add_filler();
      add_byte(QUOTE);
      add_string();
      add_byte(QUOTE);
      add_filler();
    end
    add_byte("}");
    // bytes after the closing brace are ignored up to the last one
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
  endtask

  // input side
  always @(posedge clk) begin : feed
    logic took;
    logic go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      took = s_tvalid && s_tready;
      if (took) void'(doc_feed.pop_front());
      if (src_gap > 0) begin
        src_gap--;
      end else if (src_calm > 0) begin
        src_calm--;
      end else if (doc_feed.size() > TailItems && $urandom_range(0, 7) == 0) begin
        src_gap  = $urandom_range(1, 18);
        src_calm = $urandom_range(0, 40);
      end
      // a held item waits until every queued token item has come out
      go = doc_feed.size() > 0 && src_gap == 0 &&
           (!doc_feed[0].hold || (!took && nothing_due));
      s_tvalid <= go;
      if (go) begin
        s_tdata <= doc_feed[0].data;
        s_tlast <= doc_feed[0].fin;
      end
    end
  end

  // output side
  always @(posedge clk) begin : watch
    token_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        tokenize_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (due_tokens.size() == 0) begin
          $error("unexpected item: kind %0d, data %0h", m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = due_tokens.pop_front();
          check_field("kind", want.kind, m_tuser);
          check_field("text_byte", want.text, m_tdata[7:0]);
          check_field("pair_kept", want.kept, m_tdata[8]);
          check_field("any_pair", want.any_pair, m_tdata[9]);
          check_field("end_reason", want.reason, m_tdata[11:10]);
          check_field("last_of_run", want.run_end, m_tlast);
        end
      end
      nothing_due <= (due_tokens.size() == 0);
      if (sink_gap > 0) begin
        sink_gap--;
      end else if (sink_calm > 0) begin
        sink_calm--;
      end else if (bytes_taken + TailItems < total_items && $urandom_range(0, 5) == 0) begin
        sink_gap  = $urandom_range(1, 18);
        sink_calm = $urandom_range(0, 40);
      end
      m_tready <= (sink_gap == 0);
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : run
    int doc_idx;
    int cut;
    clear_parser();

    // byte order mark, zero and ff bytes, zero codepoint, ends inside the value
    doc_bytes = '{8'hEF, 8'hBB, 8'hBF, "{", QUOTE, 8'h00, QUOTE, ":", QUOTE,
                  BSLASH, "u", "0", "0", "0", "0", 8'hFF};
    commit_doc(1'b0);
    // partial byte order mark cut short
    doc_bytes = '{8'hEF};
    commit_doc(1'b0);
    // slash as the last byte
    doc_bytes = '{"/"};
    commit_doc(1'b0);
    // unexpected byte
    doc_bytes = '{"x"};
    commit_doc(1'b0);
    // bad hex digit
    doc_bytes = '{"{", QUOTE, BSLASH, "u", "g"};
    commit_doc(1'b0);
    // unknown escape, empty value, then a lone slash
    doc_bytes = '{"{", QUOTE, BSLASH, "q", QUOTE, ":", QUOTE, QUOTE, "/", "x"};
    commit_doc(1'b0);

    doc_idx = 0;
    while (doc_feed.size() < 255) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: build_doc();
        6: begin
          build_doc();
          cut = $urandom_range(1, doc_bytes.size() - 1);
          doc_bytes = doc_bytes[0:cut-1];
        end
        7: begin
          build_doc();
          doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
        default: begin
          doc_bytes.delete();
          repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
      commit_doc(doc_idx == 2 || $urandom_range(0, 5) == 0);
      doc_idx++;
    end
    total_items = doc_feed.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (doc_feed.size() != 0 || due_tokens.size() != 0 || s_tvalid);
    repeat (20) @(negedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
